// File: rtl/jsds_pkg.sv
// shared types and constants of the jpeg sof dimension scanner
package jsds_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DIM_W   = 16;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned OFF_W   = 16;
  localparam int unsigned EARLY_W = 3;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [BYTE_W-1:0] MARK_PREFIX = 8'hFF;
  localparam logic [BYTE_W-1:0] MARK_SOI    = 8'hD8;
  localparam logic [BYTE_W-1:0] MARK_SOF0   = 8'hC0;
  localparam logic [BYTE_W-1:0] MARK_SOF2   = 8'hC2;
  localparam logic [BYTE_W-1:0] MARK_EOI    = 8'hD9;

  localparam logic [EARLY_W-1:0] EARLY_SAT   = 3'd4;
  localparam logic [OFF_W-1:0]   SOF_PREFIX  = 16'd3;
  localparam logic [OFF_W-1:0]   LEN_HDR     = 16'd2;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_INVAL = 2'd1,
    ST_NOSUP = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    PH_SOI0,
    PH_SOI1,
    PH_SCAN,
    PH_MARK,
    PH_LENHI,
    PH_LENLO,
    PH_SKIP,
    PH_SOFPRE,
    PH_HHI,
    PH_HLO,
    PH_WHI,
    PH_WLO,
    PH_TAIL
  } phase_t;

  typedef struct packed {
    logic             valid;
    status_t          status;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } result_t;

endpackage

// File: rtl/jsds_in_reg.sv
// input register stage holding one byte item
module jsds_in_reg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [jsds_pkg::BYTE_W-1:0] s_tdata,
  input  logic                       s_tlast,
  input  logic                       take,
  output logic                       valid,
  output logic [jsds_pkg::BYTE_W-1:0] data_byte,
  output logic                       last_byte
);

  assign s_tready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      data_byte <= s_tdata;
      last_byte <= s_tlast;
    end
  end

endmodule

// File: rtl/jsds_core.sv
// marker scan state and per-byte next-state logic
module jsds_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [jsds_pkg::BYTE_W-1:0] data_byte,
  input  logic                        last_byte,
  output jsds_pkg::result_t           res
);

  jsds_pkg::phase_t                phase, phase_next;
  logic [jsds_pkg::EARLY_W-1:0]    early_count, early_count_next;
  logic [jsds_pkg::OFF_W-1:0]      segment_offset, segment_offset_next;
  logic [jsds_pkg::BYTE_W-1:0]     length_hi, length_hi_next;
  logic [jsds_pkg::DIM_W-1:0]      height_hold, height_hold_next;
  logic [jsds_pkg::DIM_W-1:0]      width_hold, width_hold_next;
  logic                            decided, decided_next;
  logic [jsds_pkg::OFF_W-1:0]      offset_dec;
  logic [jsds_pkg::OFF_W-1:0]      seg_len;
  logic                            emit;
  jsds_pkg::status_t               emit_status;
  logic                            emit_dims;

  assign offset_dec = (segment_offset != '0) ? segment_offset - 16'd1 : segment_offset;
  assign seg_len    = {length_hi, data_byte};

  // next state of the scan
  always_comb begin
    phase_next          = phase;
    segment_offset_next = segment_offset;
    length_hi_next      = length_hi;
    height_hold_next    = height_hold;
    width_hold_next     = width_hold;
    decided_next        = decided;
    emit                = 1'b0;
    emit_status         = jsds_pkg::ST_OK;
    emit_dims           = 1'b0;
    early_count_next    = (early_count < jsds_pkg::EARLY_SAT) ?
                          early_count + 3'd1 : early_count;

    if (!decided) begin
      unique case (phase)
        jsds_pkg::PH_SOI0: begin
          if (data_byte != jsds_pkg::MARK_PREFIX) begin
            emit = 1'b1;
            emit_status = jsds_pkg::ST_INVAL;
          end else begin
            phase_next = jsds_pkg::PH_SOI1;
          end
        end
        jsds_pkg::PH_SOI1: begin
          if (data_byte != jsds_pkg::MARK_SOI) begin
            emit = 1'b1;
            emit_status = jsds_pkg::ST_INVAL;
          end else begin
            phase_next = jsds_pkg::PH_SCAN;
          end
        end
        jsds_pkg::PH_SCAN: begin
          if (data_byte == jsds_pkg::MARK_PREFIX) phase_next = jsds_pkg::PH_MARK;
        end
        jsds_pkg::PH_MARK: begin
          if (data_byte == jsds_pkg::MARK_SOF0 || data_byte == jsds_pkg::MARK_SOF2) begin
            segment_offset_next = jsds_pkg::SOF_PREFIX;
            phase_next = jsds_pkg::PH_SOFPRE;
          end else if (data_byte == jsds_pkg::MARK_EOI) begin
            emit = 1'b1;
            emit_status = jsds_pkg::ST_NOSUP;
          end else begin
            phase_next = jsds_pkg::PH_LENHI;
          end
        end
        jsds_pkg::PH_LENHI: begin
          length_hi_next = data_byte;
          phase_next = jsds_pkg::PH_LENLO;
        end
        jsds_pkg::PH_LENLO: begin
          if (seg_len <= jsds_pkg::LEN_HDR) begin
            phase_next = jsds_pkg::PH_SCAN;
          end else begin
            segment_offset_next = seg_len - jsds_pkg::LEN_HDR;
            phase_next = jsds_pkg::PH_SKIP;
          end
        end
        jsds_pkg::PH_SKIP: begin
          segment_offset_next = offset_dec;
          if (offset_dec == '0) phase_next = jsds_pkg::PH_SCAN;
        end
        jsds_pkg::PH_SOFPRE: begin
          segment_offset_next = offset_dec;
          if (offset_dec == '0) phase_next = jsds_pkg::PH_HHI;
        end
        jsds_pkg::PH_HHI: begin
          height_hold_next = {data_byte, height_hold[jsds_pkg::BYTE_W-1:0]};
          phase_next = jsds_pkg::PH_HLO;
        end
        jsds_pkg::PH_HLO: begin
          height_hold_next = {height_hold[jsds_pkg::DIM_W-1:jsds_pkg::BYTE_W], data_byte};
          phase_next = jsds_pkg::PH_WHI;
        end
        jsds_pkg::PH_WHI: begin
          width_hold_next = {data_byte, width_hold[jsds_pkg::BYTE_W-1:0]};
          phase_next = jsds_pkg::PH_WLO;
        end
        jsds_pkg::PH_WLO: begin
          width_hold_next = {width_hold[jsds_pkg::DIM_W-1:jsds_pkg::BYTE_W], data_byte};
          phase_next = jsds_pkg::PH_TAIL;
        end
        jsds_pkg::PH_TAIL: begin
          emit = 1'b1;
          emit_status = jsds_pkg::ST_OK;
          emit_dims = 1'b1;
        end
        default: phase_next = jsds_pkg::PH_SCAN;
      endcase
      if (emit) decided_next = 1'b1;
    end

    // end of file: answer if still open, then start over
    if (last_byte) begin
      if (!decided_next) begin
        emit = 1'b1;
        emit_status = (early_count_next < jsds_pkg::EARLY_SAT) ?
                      jsds_pkg::ST_INVAL : jsds_pkg::ST_NOSUP;
      end
      phase_next          = jsds_pkg::PH_SOI0;
      early_count_next    = '0;
      segment_offset_next = '0;
      length_hi_next      = '0;
      height_hold_next    = '0;
      width_hold_next     = '0;
      decided_next        = 1'b0;
    end
  end

  // result of this byte
  always_comb begin
    res.valid  = step && emit;
    res.status = emit_status;
    res.width  = emit_dims ? width_hold : '0;
    res.height = emit_dims ? height_hold : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= jsds_pkg::PH_SOI0;
      early_count    <= '0;
      segment_offset <= '0;
      length_hi      <= '0;
      height_hold    <= '0;
      width_hold     <= '0;
      decided        <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      early_count    <= early_count_next;
      segment_offset <= segment_offset_next;
      length_hi      <= length_hi_next;
      height_hold    <= height_hold_next;
      width_hold     <= width_hold_next;
      decided        <= decided_next;
    end
  end

  a_one_result_per_file: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (!decided || last_byte) && !(decided && !last_byte))
    else $error("second result within one file");

  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    step && last_byte |=> phase == jsds_pkg::PH_SOI0 && early_count == '0 && !decided)
    else $error("scan did not restart after last byte");

  a_skip_offset_live: assert property (@(posedge clk) disable iff (rst)
    (phase == jsds_pkg::PH_SKIP || phase == jsds_pkg::PH_SOFPRE) && !decided
    |-> segment_offset != '0)
    else $error("skip phase with empty offset");

endmodule

// File: rtl/jsds_out_reg.sv
// result register on the master side
module jsds_out_reg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             load,
  input  jsds_pkg::result_t                res,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [jsds_pkg::OUT_TDATA_W-1:0] m_tdata
);

  localparam int unsigned PAD_W = jsds_pkg::OUT_TDATA_W - jsds_pkg::STAT_W
                                  - 2 * jsds_pkg::DIM_W;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {{PAD_W{1'b0}}, res.height, res.width, res.status};
    end
  end

endmodule

// File: rtl/jpeg_sof_dimension_scanner.sv
// a byte is held in the input register; its result is loaded into m_tdata when the byte steps through the scan logic
// throughput: one byte per cycle; the only stall is a result held by m_tready low
// one result per file, from the deciding byte or from the byte flagged by s_tlast
// reset: rst (synchronous, active high) empties both registers and rearms the soi check
// no clearing pass: the block accepts bytes as soon as rst is released
module jpeg_sof_dimension_scanner (
  input  logic        clk,
  input  logic        rst,
  // byte stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte of the file
  // result stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [1:0] status, [17:2] image_width, [33:18] image_height
);

  logic                        in_valid;
  logic [jsds_pkg::BYTE_W-1:0] in_byte;
  logic                        in_last;
  logic                        out_free;
  logic                        core_step;
  jsds_pkg::result_t           core_res;

  // the result register can take a new result this cycle
  assign out_free  = !m_tvalid || m_tready;
  // one byte moves through the scan logic whenever its result has a place
  assign core_step = in_valid && out_free;

  // input register
  jsds_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .take      (core_step),
    .valid     (in_valid),
    .data_byte (in_byte),
    .last_byte (in_last)
  );

  // marker scan and dimension capture
  jsds_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (core_step),
    .data_byte (in_byte),
    .last_byte (in_last),
    .res       (core_res)
  );

  // result register
  jsds_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (core_res.valid),
    .res      (core_res),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  a_no_step_when_blocked: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !core_step)
    else $error("scan advanced while result was blocked");

  a_dims_only_when_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != jsds_pkg::ST_OK |-> m_tdata[33:2] == '0)
    else $error("dimensions on a failed result");

endmodule

// File: tb/testbench.sv
// testbench of the jpeg sof dimension scanner: byte files in, one verdict per file checked
module testbench;

  // verdict predictor and store of verdicts still owed by the block
  class sof_verdict_board;
    typedef struct packed {
      jsds_pkg::status_t          status;
      logic [jsds_pkg::DIM_W-1:0] width;
      logic [jsds_pkg::DIM_W-1:0] height;
    } verdict_t;

    verdict_t         owed_verdicts[$];
    int               errors;
    jsds_pkg::phase_t phase;
    logic [2:0]       seen_count;
    logic [16:0]      skip_left;
    logic [15:0]      seg_len;
    logic [15:0]      height_acc;
    logic [15:0]      width_acc;
    bit               decided;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      phase      = jsds_pkg::PH_SOI0;
      seen_count = '0;
      skip_left  = '0;
      seg_len    = '0;
      height_acc = '0;
      width_acc  = '0;
      decided    = 1'b0;
    endfunction

    function verdict_t verdict(jsds_pkg::status_t s, bit with_dims);
      verdict_t v;
      v.status = s;
      v.width  = with_dims ? width_acc : '0;
      v.height = with_dims ? height_acc : '0;
      return v;
    endfunction

    function int pending();
      return owed_verdicts.size();
    endfunction

    task report(string msg);
      $display("testbench: mismatch, %s", msg);
      errors++;
    endtask

    // advance the file parser by one accepted byte
    function void note_byte(logic [7:0] b, logic fin);
      verdict_t          v;
      bit                fired;
      jsds_pkg::status_t end_status;
      fired = 1'b0;
      v = verdict(jsds_pkg::ST_NOSUP, 1'b0);
      if (seen_count < jsds_pkg::EARLY_SAT) seen_count++;
      if (!decided) begin
        case (phase)
          jsds_pkg::PH_SOI0: begin
            if (b != jsds_pkg::MARK_PREFIX) begin
              v = verdict(jsds_pkg::ST_INVAL, 1'b0);
              fired = 1'b1;
            end else phase = jsds_pkg::PH_SOI1;
          end
          jsds_pkg::PH_SOI1: begin
            if (b != jsds_pkg::MARK_SOI) begin
              v = verdict(jsds_pkg::ST_INVAL, 1'b0);
              fired = 1'b1;
            end else phase = jsds_pkg::PH_SCAN;
          end
          jsds_pkg::PH_SCAN: if (b == jsds_pkg::MARK_PREFIX) phase = jsds_pkg::PH_MARK;
          jsds_pkg::PH_MARK: begin
            if (b == jsds_pkg::MARK_SOF0 || b == jsds_pkg::MARK_SOF2) begin
              skip_left = 17'(jsds_pkg::SOF_PREFIX);
              phase = jsds_pkg::PH_SOFPRE;
            end else if (b == jsds_pkg::MARK_EOI) begin
              v = verdict(jsds_pkg::ST_NOSUP, 1'b0);
              fired = 1'b1;
            end else phase = jsds_pkg::PH_LENHI;
          end
          jsds_pkg::PH_LENHI: begin
            seg_len = {b, 8'h00};
            phase = jsds_pkg::PH_LENLO;
          end
          jsds_pkg::PH_LENLO: begin
            seg_len = {seg_len[15:8], b};
            if (seg_len <= jsds_pkg::LEN_HDR) phase = jsds_pkg::PH_SCAN;
            else begin
              skip_left = 17'(seg_len - jsds_pkg::LEN_HDR);
              phase = jsds_pkg::PH_SKIP;
            end
          end
          jsds_pkg::PH_SKIP: begin
            if (skip_left > 0) skip_left--;
            if (skip_left == 0) phase = jsds_pkg::PH_SCAN;
          end
          jsds_pkg::PH_SOFPRE: begin
            if (skip_left > 0) skip_left--;
            if (skip_left == 0) phase = jsds_pkg::PH_HHI;
          end
          jsds_pkg::PH_HHI: begin
            height_acc = {b, 8'h00};
            phase = jsds_pkg::PH_HLO;
          end
          jsds_pkg::PH_HLO: begin
            height_acc = {height_acc[15:8], b};
            phase = jsds_pkg::PH_WHI;
          end
          jsds_pkg::PH_WHI: begin
            width_acc = {b, 8'h00};
            phase = jsds_pkg::PH_WLO;
          end
          jsds_pkg::PH_WLO: begin
            width_acc = {width_acc[15:8], b};
            phase = jsds_pkg::PH_TAIL;
          end
          jsds_pkg::PH_TAIL: begin
            v = verdict(jsds_pkg::ST_OK, 1'b1);
            fired = 1'b1;
          end
          default: phase = jsds_pkg::PH_SCAN;
        endcase
        if (fired) begin
          decided = 1'b1;
          owed_verdicts.push_back(v);
        end
      end
      if (fin) begin
        if (!decided) begin
          end_status = (seen_count < jsds_pkg::EARLY_SAT) ?
                       jsds_pkg::ST_INVAL : jsds_pkg::ST_NOSUP;
          owed_verdicts.push_back(verdict(end_status, 1'b0));
        end
        restart();
      end
    endfunction

    // compare one accepted result with the oldest owed verdict
    task check_verdict(logic [jsds_pkg::OUT_TDATA_W-1:0] beat);
      verdict_t   want;
      logic [1:0] got_status;
      logic [15:0] got_w;
      logic [15:0] got_h;
      got_status = beat[1:0];
      got_w      = beat[17:2];
      got_h      = beat[33:18];
      if (owed_verdicts.size() == 0) begin
        report($sformatf("result %h with nothing owed", beat));
        return;
      end
      want = owed_verdicts.pop_front();
      if (got_status != want.status)
        report($sformatf("status %0d, want %0d", got_status, want.status));
      if (got_w != want.width)
        report($sformatf("width %h, want %h", got_w, want.width));
      if (got_h != want.height)
        report($sformatf("height %h, want %h", got_h, want.height));
    endtask
  endclass

  logic                             clk;
  logic                             rst;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [7:0]                       s_tdata;
  logic                             s_tlast;
  logic                             m_tvalid;
  logic                             m_tready;
  logic [jsds_pkg::OUT_TDATA_W-1:0] m_tdata;

  sof_verdict_board sb;
  logic [7:0]       img[$];     // bytes of the file being built
  int               bytes_sent;
  bit               tx_calm;    // no source gaps for the current file
  bit               rx_calm;    // no sink stalls for the current file
  int               hold_left;

  jpeg_sof_dimension_scanner DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 2 time unit clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // height or width with extra weight on the extremes
  function automatic logic [15:0] pick_dim();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // sink side: ready drops for random stretches
  initial begin
    m_tready  = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else begin
        m_tready = 1'b1;
        if (!rx_calm && $urandom_range(0, 2) == 0) hold_left = pick_gap();
      end
    end
  end

  // results are taken at the rising edge, before the block updates
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_verdict(m_tdata);
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  = b;
    s_tlast  = fin;
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_byte(b, fin);
    bytes_sent++;
  endtask

  task automatic send_file();
    tx_calm = ($urandom_range(0, 4) == 0);
    rx_calm = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < img.size(); i++) send_byte(img[i], i == img.size() - 1);
    img.delete();
  endtask

  task automatic put_soi();
    img.push_back(jsds_pkg::MARK_PREFIX);
    img.push_back(jsds_pkg::MARK_SOI);
  endtask

  // marker segment with its length field and random body
  task automatic put_segment(input logic [7:0] mk, input int unsigned len);
    img.push_back(jsds_pkg::MARK_PREFIX);
    img.push_back(mk);
    img.push_back(len[15:8]);
    img.push_back(len[7:0]);
    for (int i = 2; i < len; i++) img.push_back(8'($urandom));
  endtask

  // frame header up to the width bytes: length and precision are don't-care
  task automatic put_frame(input logic [7:0] mk, input logic [15:0] h, input logic [15:0] w);
    img.push_back(jsds_pkg::MARK_PREFIX);
    img.push_back(mk);
    repeat (3) img.push_back(8'($urandom));
    img.push_back(h[15:8]);
    img.push_back(h[7:0]);
    img.push_back(w[15:8]);
    img.push_back(w[7:0]);
  endtask

  task automatic put_random_segments();
    logic [7:0]  mk;
    int unsigned len;
    int          r;
    repeat ($urandom_range(0, 3)) begin
      // stray non-marker bytes between segments are scanned past
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3)) img.push_back(8'($urandom_range(0, 254)));
      if ($urandom_range(0, 9) == 0) mk = jsds_pkg::MARK_PREFIX;   // fill byte
      else begin
        mk = 8'($urandom);
        if (mk == jsds_pkg::MARK_SOF0 || mk == jsds_pkg::MARK_SOF2 ||
            mk == jsds_pkg::MARK_EOI) mk = 8'hE1;
      end
      r = $urandom_range(0, 99);
      if (r < 8) len = $urandom_range(0, 2);
      else if (r < 96) len = $urandom_range(3, 16);
      else len = $urandom_range(17, 300);
      put_segment(mk, len);
    end
  endtask

  task automatic build_random_file();
    int r;
    int cut;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      put_soi();
      put_random_segments();
      put_frame(($urandom_range(0, 1) == 0) ? jsds_pkg::MARK_SOF0 : jsds_pkg::MARK_SOF2,
                pick_dim(), pick_dim());
      repeat ($urandom_range(1, 4)) img.push_back(8'($urandom));
      if ($urandom_range(0, 2) == 0) begin
        img.push_back(jsds_pkg::MARK_PREFIX);
        img.push_back(jsds_pkg::MARK_EOI);
      end
      // part of the well-formed files get cut short
      if (r >= 68) begin
        cut = $urandom_range(1, img.size() - 1);
        repeat (cut) void'(img.pop_back());
      end
    end else if (r < 87) begin
      put_soi();
      put_random_segments();
      img.push_back(jsds_pkg::MARK_PREFIX);
      img.push_back(jsds_pkg::MARK_EOI);
      repeat ($urandom_range(0, 3)) img.push_back(8'($urandom));
    end else if (r < 91) begin
      // segment that runs past the end of the file
      put_soi();
      img.push_back(jsds_pkg::MARK_PREFIX);
      img.push_back(8'hE0);
      img.push_back(8'($urandom));
      img.push_back(8'($urandom));
      repeat ($urandom_range(0, 6)) img.push_back(8'($urandom));
    end else if (r < 96) begin
      // broken start of image
      repeat ($urandom_range(1, 6)) img.push_back(8'($urandom));
      if ($urandom_range(0, 1) == 0) img[0] = jsds_pkg::MARK_PREFIX;
    end else begin
      put_soi();
      repeat ($urandom_range(0, 40)) img.push_back(8'($urandom));
    end
  endtask

  initial begin
    #2000000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    sb         = new();
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tlast    = 1'b0;
    bytes_sent = 0;
    tx_calm    = 1'b0;
    rx_calm    = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // frame header with zero dimensions
    put_soi(); put_frame(jsds_pkg::MARK_SOF0, 16'h0000, 16'h0000); img.push_back(8'h00);
    send_file();
    // progressive header at full scale, bytes after the decision are ignored
    put_soi(); put_frame(jsds_pkg::MARK_SOF2, 16'hFFFF, 16'hFFFF); img.push_back(8'hA5);
    img.push_back(jsds_pkg::MARK_PREFIX); img.push_back(jsds_pkg::MARK_EOI);
    send_file();
    // bad first byte
    img.push_back(8'h00); img.push_back(jsds_pkg::MARK_PREFIX);
    img.push_back(jsds_pkg::MARK_SOI);
    send_file();
    // bad second byte
    img.push_back(jsds_pkg::MARK_PREFIX); img.push_back(jsds_pkg::MARK_EOI);
    img.push_back(8'h12); img.push_back(8'h34);
    send_file();
    // short files of one, two and three bytes
    img.push_back(jsds_pkg::MARK_PREFIX);
    send_file();
    put_soi();
    send_file();
    put_soi(); img.push_back(jsds_pkg::MARK_PREFIX);
    send_file();
    // four bytes, no marker
    put_soi(); img.push_back(8'h00); img.push_back(8'h00);
    send_file();
    // end of image marker
    put_soi(); img.push_back(jsds_pkg::MARK_PREFIX); img.push_back(jsds_pkg::MARK_EOI);
    img.push_back(8'h5A);
    send_file();
    // segment lengths 0, 1 and 2 resume the search
    put_soi(); put_segment(8'hE0, 0); put_segment(8'hE1, 1); put_segment(8'hE2, 2);
    put_frame(jsds_pkg::MARK_SOF0, 16'h1234, 16'h5678); img.push_back(8'h9A);
    send_file();
    // fill byte read as a marker with its own length
    put_soi(); put_segment(jsds_pkg::MARK_PREFIX, 4);
    put_frame(jsds_pkg::MARK_SOF2, 16'h0001, 16'h8000);
    img.push_back(8'h00);
    send_file();
    // frame header that ends on the width bytes
    put_soi(); put_frame(jsds_pkg::MARK_SOF0, 16'h0102, 16'h0304);
    send_file();
    // segment longer than the rest of the file
    put_soi(); img.push_back(jsds_pkg::MARK_PREFIX); img.push_back(8'hE0);
    img.push_back(8'hFF); img.push_back(8'hFF); img.push_back(8'h00); img.push_back(8'h00);
    send_file();
    // pad bytes and an ordinary segment before the frame
    put_soi(); img.push_back(8'h00); img.push_back(8'h7F); img.push_back(8'h80);
    put_segment(8'hDB, 5); put_frame(jsds_pkg::MARK_SOF0, 16'hA5A5, 16'h5A5A);
    img.push_back(8'hFF);
    send_file();

    while (bytes_sent < 1200) begin
      build_random_file();
      send_file();
    end

    @(negedge clk);
    s_tvalid = 1'b0;
    s_tlast  = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
